// ===== hdl/dnrs_pkg.sv =====
// shared types and constants of the directional nearest rectangle selector
package dnrs_pkg;

   localparam int COORD_BITS_DEFAULT  = 16;
   localparam int ID_BITS_DEFAULT     = 29;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_INDEX_BITS = 3;

   // register index on the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DIRECTION = 3'd0,
      REG_FOCUS_X   = 3'd1,
      REG_FOCUS_Y   = 3'd2,
      REG_REGION_X  = 3'd3,
      REG_REGION_Y  = 3'd4,
      REG_REGION_W  = 3'd5,
      REG_REGION_H  = 3'd6
   } dnrs_reg_type;

   // search direction codes
   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_DOWN  = 2'd3
   } dnrs_dir_type;

   // classification attached to each queued candidate
   typedef struct packed {
      logic qual;
      logic last;
   } dnrs_tag_type;

   localparam int TAG_BITS = $bits(dnrs_tag_type);

endpackage

// ===== hdl/directional_nearest_rect_select_unit.sv =====
// top level of the directional nearest rectangle selector
//
// candidate rectangles stream in on the req_ channel, one transfer per cycle at full
// rate. each candidate whose origin lies inside the configured region (bounds inclusive)
// and on the configured side of the focus point is compared against the running best;
// on the candidate flagged last_rect one transfer leaves on the rsp_ channel with found
// and the chosen id (0 when nothing qualified) and the running best is cleared for the
// next list. the front end classifies a candidate in the cycle it is taken and writes it
// into a small queue; the back end pops one entry per cycle unless a held result blocks
// it, and its combinational compare against the running best sets the sustained rate
// of one candidate per clock. rsp_valid is registered once the last candidate is popped.
// a pending result held by rsp_stall only blocks the next last candidate; other
// candidates keep draining, and req_stall rises only when the queue fills.
// configuration registers sit at byte offsets 4*i: direction, focus_x, focus_y,
// region_x, region_y, region_w, region_h; write them only while no list is in flight.
module directional_nearest_rect_select_unit #(
   parameter int COORD_BITS  = dnrs_pkg::COORD_BITS_DEFAULT,
   parameter int ID_BITS     = dnrs_pkg::ID_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = dnrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // candidate channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic        [ID_BITS-1:0]          req_rect_id,
   input  logic signed [COORD_BITS-1:0]       req_rect_x,
   input  logic signed [COORD_BITS-1:0]       req_rect_y,
   input  logic        [COORD_BITS-1:0]       req_rect_w,
   input  logic        [COORD_BITS-1:0]       req_rect_h,
   input  logic                               req_last_rect,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic        [ID_BITS-1:0]          rsp_chosen_id,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dnrs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [dnrs_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [dnrs_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   // queue entry: classification tag, id, x, y, w, h
   localparam int ENTRY_BITS = dnrs_pkg::TAG_BITS + ID_BITS + 4 * COORD_BITS;

   dnrs_pkg::dnrs_dir_type       direction;
   logic signed [COORD_BITS-1:0] focus_x, focus_y, region_x, region_y;
   logic        [COORD_BITS-1:0] region_w, region_h;

   logic                         push, push_ready, pop, entry_valid;
   logic [ENTRY_BITS-1:0]        push_data, entry_data;

   // register file; the user must keep it static while a list is in flight, the block does not enforce it
   dnrs_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .direction (direction),
      .focus_x   (focus_x),
      .focus_y   (focus_y),
      .region_x  (region_x),
      .region_y  (region_y),
      .region_w  (region_w),
      .region_h  (region_h)
   );

   // region and direction test at the moment of transfer
   dnrs_front #(
      .COORD_BITS (COORD_BITS),
      .ID_BITS    (ID_BITS)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rect_id   (req_rect_id),
      .req_rect_x    (req_rect_x),
      .req_rect_y    (req_rect_y),
      .req_rect_w    (req_rect_w),
      .req_rect_h    (req_rect_h),
      .req_last_rect (req_last_rect),
      .direction     (direction),
      .focus_x       (focus_x),
      .focus_y       (focus_y),
      .region_x      (region_x),
      .region_y      (region_y),
      .region_w      (region_w),
      .region_h      (region_h),
      .push          (push),
      .push_data     (push_data),
      .push_ready    (push_ready)
   );

   // decouples the input side from a stalled result
   dnrs_queue #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_data   (entry_data),
      .pop_valid  (entry_valid)
   );

   // ordered comparison against the running best, result register
   dnrs_back #(
      .COORD_BITS (COORD_BITS),
      .ID_BITS    (ID_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (entry_valid),
      .entry_data    (entry_data),
      .pop           (pop),
      .direction     (direction),
      .focus_x       (focus_x),
      .focus_y       (focus_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_chosen_id (rsp_chosen_id)
   );

endmodule

// ===== hdl/dnrs_csr.sv =====
// configuration register file with apb-style access
module dnrs_csr #(
   parameter int COORD_BITS = dnrs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dnrs_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dnrs_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dnrs_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output dnrs_pkg::dnrs_dir_type               direction,
   output logic signed [COORD_BITS-1:0]         focus_x,
   output logic signed [COORD_BITS-1:0]         focus_y,
   output logic signed [COORD_BITS-1:0]         region_x,
   output logic signed [COORD_BITS-1:0]         region_y,
   output logic        [COORD_BITS-1:0]         region_w,
   output logic        [COORD_BITS-1:0]         region_h
);

   dnrs_pkg::dnrs_dir_type         direction_ff;
   logic signed [COORD_BITS-1:0]   focus_x_ff, focus_y_ff, region_x_ff, region_y_ff;
   logic        [COORD_BITS-1:0]   region_w_ff, region_h_ff;
   dnrs_pkg::dnrs_reg_type         reg_index;
   logic                           write_en;

   assign reg_index = dnrs_pkg::dnrs_reg_type'(paddr[dnrs_pkg::CSR_ADDR_BITS-1:2]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= dnrs_pkg::DIR_LEFT;
         focus_x_ff   <= '0;
         focus_y_ff   <= '0;
         region_x_ff  <= '0;
         region_y_ff  <= '0;
         region_w_ff  <= '0;
         region_h_ff  <= '0;
      end else if (write_en) begin
         case (reg_index)
            dnrs_pkg::REG_DIRECTION: begin
               direction_ff <= dnrs_pkg::dnrs_dir_type'(pwdata[1:0]);
            end
            dnrs_pkg::REG_FOCUS_X: begin
               focus_x_ff <= pwdata[COORD_BITS-1:0];
            end
            dnrs_pkg::REG_FOCUS_Y: begin
               focus_y_ff <= pwdata[COORD_BITS-1:0];
            end
            dnrs_pkg::REG_REGION_X: begin
               region_x_ff <= pwdata[COORD_BITS-1:0];
            end
            dnrs_pkg::REG_REGION_Y: begin
               region_y_ff <= pwdata[COORD_BITS-1:0];
            end
            dnrs_pkg::REG_REGION_W: begin
               region_w_ff <= pwdata[COORD_BITS-1:0];
            end
            dnrs_pkg::REG_REGION_H: begin
               region_h_ff <= pwdata[COORD_BITS-1:0];
            end
            default: begin
               // unmapped address, write dropped
            end
         endcase
      end
   end

   // signed registers read back sign-extended
   always_comb begin
      case (reg_index)
         dnrs_pkg::REG_DIRECTION: prdata = dnrs_pkg::CSR_DATA_BITS'(direction_ff);
         dnrs_pkg::REG_FOCUS_X:   prdata = dnrs_pkg::CSR_DATA_BITS'(focus_x_ff);
         dnrs_pkg::REG_FOCUS_Y:   prdata = dnrs_pkg::CSR_DATA_BITS'(focus_y_ff);
         dnrs_pkg::REG_REGION_X:  prdata = dnrs_pkg::CSR_DATA_BITS'(region_x_ff);
         dnrs_pkg::REG_REGION_Y:  prdata = dnrs_pkg::CSR_DATA_BITS'(region_y_ff);
         dnrs_pkg::REG_REGION_W:  prdata = dnrs_pkg::CSR_DATA_BITS'(region_w_ff);
         dnrs_pkg::REG_REGION_H:  prdata = dnrs_pkg::CSR_DATA_BITS'(region_h_ff);
         default:                 prdata = '0;
      endcase
   end

   assign direction = direction_ff;
   assign focus_x   = focus_x_ff;
   assign focus_y   = focus_y_ff;
   assign region_x  = region_x_ff;
   assign region_y  = region_y_ff;
   assign region_w  = region_w_ff;
   assign region_h  = region_h_ff;

endmodule

// ===== hdl/dnrs_front.sv =====
// front end: accepts candidates and classifies them against region and direction
module dnrs_front #(
   parameter int COORD_BITS = dnrs_pkg::COORD_BITS_DEFAULT,
   parameter int ID_BITS    = dnrs_pkg::ID_BITS_DEFAULT,
   localparam int ENTRY_BITS = dnrs_pkg::TAG_BITS + ID_BITS + 4 * COORD_BITS
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic        [ID_BITS-1:0]    req_rect_id,
   input  logic signed [COORD_BITS-1:0] req_rect_x,
   input  logic signed [COORD_BITS-1:0] req_rect_y,
   input  logic        [COORD_BITS-1:0] req_rect_w,
   input  logic        [COORD_BITS-1:0] req_rect_h,
   input  logic                         req_last_rect,
   input  dnrs_pkg::dnrs_dir_type       direction,
   input  logic signed [COORD_BITS-1:0] focus_x,
   input  logic signed [COORD_BITS-1:0] focus_y,
   input  logic signed [COORD_BITS-1:0] region_x,
   input  logic signed [COORD_BITS-1:0] region_y,
   input  logic        [COORD_BITS-1:0] region_w,
   input  logic        [COORD_BITS-1:0] region_h,
   output logic                         push,
   output logic [ENTRY_BITS-1:0]        push_data,
   input  logic                         push_ready
);

   localparam int EXT_BITS = COORD_BITS + 2;

   logic signed [EXT_BITS-1:0] x_ext, y_ext, left_ext, top_ext, right_ext, bottom_ext;
   logic                       in_region, dir_ok;
   dnrs_pkg::dnrs_tag_type     tag;

   assign x_ext      = EXT_BITS'(req_rect_x);
   assign y_ext      = EXT_BITS'(req_rect_y);
   assign left_ext   = EXT_BITS'(region_x);
   assign top_ext    = EXT_BITS'(region_y);
   assign right_ext  = left_ext + $signed({2'b00, region_w});
   assign bottom_ext = top_ext + $signed({2'b00, region_h});

   // region bounds are inclusive on all four sides
   assign in_region = (x_ext >= left_ext) && (x_ext <= right_ext) &&
                      (y_ext >= top_ext) && (y_ext <= bottom_ext);

   always_comb begin
      case (direction)
         dnrs_pkg::DIR_LEFT:  dir_ok = req_rect_x < focus_x;
         dnrs_pkg::DIR_RIGHT: dir_ok = req_rect_x > focus_x;
         dnrs_pkg::DIR_UP:    dir_ok = req_rect_y < focus_y;
         dnrs_pkg::DIR_DOWN:  dir_ok = req_rect_y > focus_y;
         default:             dir_ok = 1'b0;
      endcase
   end

   assign tag.qual = in_region && dir_ok;
   assign tag.last = req_last_rect;

   assign req_stall = !push_ready;
   assign push      = req_valid && push_ready;
   assign push_data = {tag, req_rect_id, req_rect_x, req_rect_y, req_rect_w, req_rect_h};

endmodule

// ===== hdl/dnrs_queue.sv =====
// short fifo between the front and back ends
module dnrs_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = dnrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 push_ready,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 pop_valid
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0]  data_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign push_ready = count_ff != COUNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/dnrs_back.sv =====
// back end: running-best comparison and result register
module dnrs_back #(
   parameter int COORD_BITS = dnrs_pkg::COORD_BITS_DEFAULT,
   parameter int ID_BITS    = dnrs_pkg::ID_BITS_DEFAULT,
   localparam int ENTRY_BITS = dnrs_pkg::TAG_BITS + ID_BITS + 4 * COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         entry_valid,
   input  logic [ENTRY_BITS-1:0]        entry_data,
   output logic                         pop,
   input  dnrs_pkg::dnrs_dir_type       direction,
   input  logic signed [COORD_BITS-1:0] focus_x,
   input  logic signed [COORD_BITS-1:0] focus_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic        [ID_BITS-1:0]    rsp_chosen_id
);

   localparam int EXT_BITS  = COORD_BITS + 2;
   localparam int DIST_BITS = COORD_BITS + 1;

   dnrs_pkg::dnrs_tag_type       tag;
   logic        [ID_BITS-1:0]    id;
   logic signed [COORD_BITS-1:0] x, y;
   logic        [COORD_BITS-1:0] w, h;

   logic                         best_valid_ff, best_valid_in;
   logic        [ID_BITS-1:0]    best_id_ff;
   logic signed [COORD_BITS-1:0] best_x_ff, best_y_ff;
   logic        [COORD_BITS-1:0] best_w_ff, best_h_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic        [ID_BITS-1:0]    rsp_chosen_id_ff;

   logic                         horiz, toward_neg;
   logic signed [COORD_BITS-1:0] cand_a, cand_b, best_a, best_b, focus_b;
   logic        [COORD_BITS-1:0] cand_sz, best_sz;
   logic signed [EXT_BITS-1:0]   cand_a_ext, best_a_ext;
   logic signed [DIST_BITS-1:0]  cand_diff, best_diff;
   logic        [DIST_BITS-1:0]  cand_dist, best_dist;
   logic                         same_line, beyond, tie_closer, beats, take;
   logic                         out_free, found_now;
   logic        [ID_BITS-1:0]    id_now;

   assign {tag, id, x, y, w, h} = entry_data;

   // vertical search swaps the roles of x and y
   assign horiz      = (direction == dnrs_pkg::DIR_LEFT) || (direction == dnrs_pkg::DIR_RIGHT);
   assign toward_neg = (direction == dnrs_pkg::DIR_LEFT) || (direction == dnrs_pkg::DIR_UP);

   assign cand_a  = horiz ? x : y;
   assign cand_b  = horiz ? y : x;
   assign cand_sz = horiz ? w : h;
   assign best_a  = horiz ? best_x_ff : best_y_ff;
   assign best_b  = horiz ? best_y_ff : best_x_ff;
   assign best_sz = horiz ? best_w_ff : best_h_ff;
   assign focus_b = horiz ? focus_y : focus_x;

   assign cand_a_ext = EXT_BITS'(cand_a);
   assign best_a_ext = EXT_BITS'(best_a);

   // candidate on the focus row or column while the best is not
   assign same_line = (cand_b == focus_b) && (best_b != focus_b);

   // whole separation beyond the best's far edge
   assign beyond = toward_neg ?
                   (cand_a_ext > best_a_ext + $signed({2'b00, best_sz})) :
                   (cand_a_ext + $signed({2'b00, cand_sz}) < best_a_ext);

   assign cand_diff  = DIST_BITS'(cand_b) - DIST_BITS'(focus_b);
   assign best_diff  = DIST_BITS'(best_b) - DIST_BITS'(focus_b);
   assign cand_dist  = cand_diff[DIST_BITS-1] ? DIST_BITS'(-cand_diff) : DIST_BITS'(cand_diff);
   assign best_dist  = best_diff[DIST_BITS-1] ? DIST_BITS'(-best_diff) : DIST_BITS'(best_diff);
   assign tie_closer = (cand_a == best_a) && (cand_dist < best_dist);

   assign beats = !best_valid_ff || same_line || beyond || tie_closer;
   assign take  = tag.qual && beats;

   // only a last item needs the result register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = entry_valid && (!tag.last || out_free);

   assign found_now = take || best_valid_ff;
   assign id_now    = take ? id : (best_valid_ff ? best_id_ff : '0);

   always_comb begin
      best_valid_in = best_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (pop) begin
         if (tag.last) begin
            best_valid_in = 1'b0;
            rsp_valid_in  = 1'b1;
         end else if (take) begin
            best_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && take && !tag.last) begin
         best_id_ff <= id;
         best_x_ff  <= x;
         best_y_ff  <= y;
         best_w_ff  <= w;
         best_h_ff  <= h;
      end
      if (pop && tag.last) begin
         rsp_found_ff     <= found_now;
         rsp_chosen_id_ff <= id_now;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_chosen_id = rsp_chosen_id_ff;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the directional nearest rectangle selector
`timescale 1ns / 1ps

module testbench;

   localparam int COORD_BITS      = dnrs_pkg::COORD_BITS_DEFAULT;
   localparam int ID_BITS         = dnrs_pkg::ID_BITS_DEFAULT;
   localparam int ADDR_BITS       = dnrs_pkg::CSR_ADDR_BITS;
   localparam int DATA_BITS       = dnrs_pkg::CSR_DATA_BITS;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 105;
   // drain wait covers the candidate queue and the result register, with margin
   localparam int DRAIN_CYCLES    = 12;
   localparam int LONG_HOLD       = 300;
   localparam int CYCLE_LIMIT     = 400000;
   // register index that the block does not implement
   localparam int REG_SPARE       = 7;
   localparam logic [ID_BITS-1:0] ID_MAX = '1;

   typedef struct {
      logic        [ID_BITS-1:0]    id;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic        [COORD_BITS-1:0] w;
      logic        [COORD_BITS-1:0] h;
      logic                         last;
   } rect_type;

   typedef struct {
      logic               found;
      logic [ID_BITS-1:0] chosen_id;
   } choice_type;

   typedef enum {ROW_CSR, ROW_RECT} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           reg_index;
      logic [31:0]  reg_value;
      rect_type     rect;
      bit           typed;
      choice_type   typed_choice;
   } row_type;

   // dut signals, inputs known from time zero
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic        [ID_BITS-1:0]          req_rect_id = '0;
   logic signed [COORD_BITS-1:0]       req_rect_x = '0;
   logic signed [COORD_BITS-1:0]       req_rect_y = '0;
   logic        [COORD_BITS-1:0]       req_rect_w = '0;
   logic        [COORD_BITS-1:0]       req_rect_h = '0;
   logic                               req_last_rect = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_found;
   logic        [ID_BITS-1:0]          rsp_chosen_id;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [ADDR_BITS-1:0]               paddr = '0;
   logic [DATA_BITS-1:0]               pwdata = '0;
   logic [DATA_BITS-1:0]               prdata;
   logic                               pready;

   // predictor copy of the configuration, reset values
   dnrs_pkg::dnrs_dir_type       cfg_dir      = dnrs_pkg::DIR_LEFT;
   logic signed [COORD_BITS-1:0] cfg_focus_x  = '0;
   logic signed [COORD_BITS-1:0] cfg_focus_y  = '0;
   logic signed [COORD_BITS-1:0] cfg_region_x = '0;
   logic signed [COORD_BITS-1:0] cfg_region_y = '0;
   logic        [COORD_BITS-1:0] cfg_region_w = '0;
   logic        [COORD_BITS-1:0] cfg_region_h = '0;

   // predictor copy of the running best
   bit       best_valid = 1'b0;
   rect_type best_rect  = '{default: '0};

   choice_type pending_choices[$];
   row_type    directed_rows[$];
   int         mismatches = 0;
   int         cycle_count = 0;
   bit         calm = 1'b0;
   bit         long_hold_req = 1'b0;

   directional_nearest_rect_select_unit #(
      .COORD_BITS(COORD_BITS),
      .ID_BITS   (ID_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rect_id  (req_rect_id),
      .req_rect_x   (req_rect_x),
      .req_rect_y   (req_rect_y),
      .req_rect_w   (req_rect_w),
      .req_rect_h   (req_rect_h),
      .req_last_rect(req_last_rect),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_found    (rsp_found),
      .rsp_chosen_id(rsp_chosen_id),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // absolute distance on widened values
   function automatic longint gap_of(longint a, longint b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // origin inside the region (inclusive) and on the search side of the focus
   function automatic bit rect_qualifies(rect_type r);
      longint x, y, rx, ry, rw, rh;
      x  = longint'(r.x);
      y  = longint'(r.y);
      rx = longint'(cfg_region_x);
      ry = longint'(cfg_region_y);
      rw = longint'(cfg_region_w);
      rh = longint'(cfg_region_h);
      if (x < rx || x > rx + rw || y < ry || y > ry + rh)
         return 1'b0;
      case (cfg_dir)
         dnrs_pkg::DIR_LEFT:  return x < longint'(cfg_focus_x);
         dnrs_pkg::DIR_RIGHT: return x > longint'(cfg_focus_x);
         dnrs_pkg::DIR_UP:    return y < longint'(cfg_focus_y);
         default:             return y > longint'(cfg_focus_y);
      endcase
   endfunction

   // ordered replacement rules; vertical search swaps the axes
   function automatic bit beats_running_best(rect_type r);
      longint x, y, w, h, bx, by, bw, bh, fx, fy;
      x  = longint'(r.x);
      y  = longint'(r.y);
      w  = longint'(r.w);
      h  = longint'(r.h);
      bx = longint'(best_rect.x);
      by = longint'(best_rect.y);
      bw = longint'(best_rect.w);
      bh = longint'(best_rect.h);
      fx = longint'(cfg_focus_x);
      fy = longint'(cfg_focus_y);
      if (!best_valid)
         return 1'b1;
      if (cfg_dir == dnrs_pkg::DIR_LEFT || cfg_dir == dnrs_pkg::DIR_RIGHT) begin
         // same row as the focus wins over a best that is off the row
         if (y == fy && by != fy)
            return 1'b1;
         // fully beyond the far edge of the best
         if (cfg_dir == dnrs_pkg::DIR_LEFT && x > bx + bw)
            return 1'b1;
         if (cfg_dir == dnrs_pkg::DIR_RIGHT && x + w < bx)
            return 1'b1;
         // equal start, nearer on the other axis
         return x == bx && gap_of(y, fy) < gap_of(by, fy);
      end
      if (x == fx && bx != fx)
         return 1'b1;
      if (cfg_dir == dnrs_pkg::DIR_UP && y > by + bh)
         return 1'b1;
      if (cfg_dir == dnrs_pkg::DIR_DOWN && y + h < by)
         return 1'b1;
      return y == by && gap_of(x, fx) < gap_of(bx, fx);
   endfunction

   // advance the running best by one candidate; a last candidate yields a choice
   task automatic track_rect(input rect_type r, output bit emits, output choice_type ch);
      if (rect_qualifies(r) && beats_running_best(r)) begin
         best_valid = 1'b1;
         best_rect  = r;
      end
      emits        = r.last;
      ch.found     = best_valid;
      ch.chosen_id = best_valid ? best_rect.id : '0;
      if (r.last) begin
         best_valid = 1'b0;
         best_rect  = '{default: '0};
      end
   endtask

   // sender gap with valid low, its length set by n
   task automatic idle_sender(input int n);
      @(negedge clock) req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // one candidate transfer, then record what it should produce
   task automatic offer_rect(input rect_type r, input bit typed,
                             input choice_type typed_choice);
      bit         emits;
      choice_type ch;
      if (!calm && $urandom_range(0, 99) < 25)
         idle_sender(int'($urandom_range(1, 18)));
      @(negedge clock);
      req_valid     <= 1'b1;
      req_rect_id   <= r.id;
      req_rect_x    <= r.x;
      req_rect_y    <= r.y;
      req_rect_w    <= r.w;
      req_rect_h    <= r.h;
      req_last_rect <= r.last;
      do @(posedge clock); while (req_stall);
      track_rect(r, emits, ch);
      if (emits)
         pending_choices.push_back(typed ? typed_choice : ch);
   endtask

   // sender stops until every choice has arrived and the queue has drained
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup then access cycle, then mirror the write in the predictor
   task automatic csr_write(input int idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_BITS'(idx * 4);
      pwdata  <= value;
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         dnrs_pkg::REG_DIRECTION: cfg_dir      = dnrs_pkg::dnrs_dir_type'(value[1:0]);
         dnrs_pkg::REG_FOCUS_X:   cfg_focus_x  = value[COORD_BITS-1:0];
         dnrs_pkg::REG_FOCUS_Y:   cfg_focus_y  = value[COORD_BITS-1:0];
         dnrs_pkg::REG_REGION_X:  cfg_region_x = value[COORD_BITS-1:0];
         dnrs_pkg::REG_REGION_Y:  cfg_region_y = value[COORD_BITS-1:0];
         dnrs_pkg::REG_REGION_W:  cfg_region_w = value[COORD_BITS-1:0];
         dnrs_pkg::REG_REGION_H:  cfg_region_h = value[COORD_BITS-1:0];
         default: ;
      endcase
   endtask

   function automatic void add_csr(input int idx, input int value);
      row_type row;
      row.kind      = ROW_CSR;
      row.reg_index = idx;
      row.reg_value = value;
      row.rect      = '{default: '0};
      row.typed     = 1'b0;
      row.typed_choice = '{default: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_rect(input int id, input int x, input int y, input int w,
                                    input int h, input bit last, input bit typed = 1'b0,
                                    input bit found = 1'b0, input int chosen = 0);
      row_type row;
      row.kind      = ROW_RECT;
      row.reg_index = 0;
      row.reg_value = '0;
      row.rect.id   = ID_BITS'(id);
      row.rect.x    = COORD_BITS'(x);
      row.rect.y    = COORD_BITS'(y);
      row.rect.w    = COORD_BITS'(w);
      row.rect.h    = COORD_BITS'(h);
      row.rect.last = last;
      row.typed     = typed;
      row.typed_choice.found     = found;
      row.typed_choice.chosen_id = ID_BITS'(chosen);
      directed_rows.push_back(row);
   endfunction

   // coordinate near the focus, repeated, inside the region, or anywhere
   function automatic logic [COORD_BITS-1:0] pick_coord(input longint center,
                                                        input longint lo,
                                                        input int unsigned span_w,
                                                        input logic [COORD_BITS-1:0] prev);
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 45)
         return COORD_BITS'(center + longint'($urandom_range(0, 16)) - 8);
      if (roll < 60)
         return prev;
      if (roll < 85)
         return COORD_BITS'(lo + longint'($urandom_range(0, span_w)));
      return COORD_BITS'($urandom);
   endfunction

   // mostly small sizes, sometimes any 16-bit value
   function automatic logic [COORD_BITS-1:0] pick_size();
      if ($urandom_range(0, 99) < 80)
         return COORD_BITS'($urandom_range(0, 20));
      return COORD_BITS'($urandom);
   endfunction

   // result checker: each transfer against the oldest expected choice
   always @(posedge clock) begin : check_results
      choice_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_choices.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual found %0d id %h",
                     $time, rsp_found, rsp_chosen_id);
            mismatches++;
         end else begin
            want = pending_choices.pop_front();
            if (rsp_found !== want.found) begin
               $display("%0t: found mismatch, expected %0d, actual %0d",
                        $time, want.found, rsp_found);
               mismatches++;
            end
            if (rsp_chosen_id !== want.chosen_id) begin
               $display("%0t: chosen_id mismatch, expected %h, actual %h",
                        $time, want.chosen_id, rsp_chosen_id);
               mismatches++;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request, none when calm
   initial begin : drive_rsp_stall
      int burst_left;
      int hold_left;
      bit hold_done;
      burst_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req && !hold_done) begin
            // long hold so the queue fills and the input stalls
            hold_done  = 1'b1;
            hold_left  = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < 15) begin
            burst_left = int'($urandom_range(1, 18)) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      int                           p, n, len, k;
      rect_type                     r;
      choice_type                   none;
      logic signed [COORD_BITS-1:0] fx, fy, rx, ry;
      logic        [COORD_BITS-1:0] rw, rh, px, py;

      none = '{default: '0};
      px   = '0;
      py   = '0;

      // reset config: search left, focus at origin, region a single point
      add_rect(int'(ID_MAX), -32768, -32768, 65535, 65535, 1'b1, 1'b1, 1'b0, 0);
      // origin on the point region but not left of the focus
      add_rect(0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0, 0);
      // no result until the last candidate
      add_rect(5, 32767, 32767, 1, 1, 1'b0);
      add_rect(6, -1, 0, 0, 0, 1'b1, 1'b1, 1'b0, 0);
      // zero-size region still admits an origin on its edge
      add_csr(dnrs_pkg::REG_REGION_X, -20);
      // unimplemented register is ignored
      add_csr(REG_SPARE, 32'h0000_ffff);
      add_rect(21, -20, 0, 3, 3, 1'b1, 1'b1, 1'b1, 21);
      // left search over the whole plane
      add_csr(dnrs_pkg::REG_FOCUS_X, 100);
      add_csr(dnrs_pkg::REG_FOCUS_Y, 50);
      add_csr(dnrs_pkg::REG_REGION_X, -32768);
      add_csr(dnrs_pkg::REG_REGION_Y, -32768);
      add_csr(dnrs_pkg::REG_REGION_W, 65535);
      add_csr(dnrs_pkg::REG_REGION_H, 65535);
      add_rect(11, 50, 80, 20, 4, 1'b0);
      add_rect(12, 80, 50, 5, 5, 1'b0);
      add_rect(13, 40, 50, 5, 5, 1'b0);
      add_rect(14, 90, 60, 2, 2, 1'b0);
      add_rect(15, 90, 55, 1, 1, 1'b1);
      // right search from the lowest focus x
      add_csr(dnrs_pkg::REG_DIRECTION, dnrs_pkg::DIR_RIGHT);
      add_csr(dnrs_pkg::REG_FOCUS_X, -32768);
      add_csr(dnrs_pkg::REG_FOCUS_Y, 0);
      add_rect(31, 200, 7, 10, 0, 1'b0);
      add_rect(32, 100, 9, 50, 0, 1'b0);
      add_rect(33, 32767, 32767, 65535, 65535, 1'b1);
      // up search from the highest focus y
      add_csr(dnrs_pkg::REG_DIRECTION, dnrs_pkg::DIR_UP);
      add_csr(dnrs_pkg::REG_FOCUS_X, 0);
      add_csr(dnrs_pkg::REG_FOCUS_Y, 32767);
      add_rect(41, 3, -100, 0, 10, 1'b0);
      add_rect(42, 0, 500, 0, 0, 1'b0);
      add_rect(43, 9, 32766, 0, 0, 1'b1);
      // down search, equal-start tie then nearer column
      add_csr(dnrs_pkg::REG_DIRECTION, dnrs_pkg::DIR_DOWN);
      add_csr(dnrs_pkg::REG_FOCUS_Y, -32768);
      add_rect(51, 5, 100, 0, 0, 1'b0);
      add_rect(52, -5, 100, 0, 0, 1'b0);
      add_rect(53, 2, 20, 0, 79, 1'b0);
      add_rect(int'(ID_MAX), 1, 20, 0, 0, 1'b1);

      // hold reset, then release it on a falling clock edge
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle();
            csr_write(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            offer_rect(directed_rows[i].rect, directed_rows[i].typed,
                       directed_rows[i].typed_choice);
         end
      end

      // random phases, each with its own configuration
      for (p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         calm = (p == 4) || (p >= RANDOM_PHASES - 2);
         if ($urandom_range(0, 2) == 0) begin
            fx = COORD_BITS'($urandom);
            fy = COORD_BITS'($urandom);
         end else begin
            fx = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
            fy = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
         end
         // opposite corners of the coordinate range
         if (p == 1) begin
            fx = 16'sh7fff;
            fy = 16'sh8000;
         end else if (p == 2) begin
            fx = 16'sh8000;
            fy = 16'sh7fff;
         end
         case ($urandom_range(0, 3))
            0: begin
               rx = 16'sh8000;
               ry = 16'sh8000;
               rw = 16'hffff;
               rh = 16'hffff;
            end
            1: begin
               rx = COORD_BITS'(int'(fx) - int'($urandom_range(0, 64)));
               ry = COORD_BITS'(int'(fy) - int'($urandom_range(0, 64)));
               rw = COORD_BITS'($urandom_range(0, 160));
               rh = COORD_BITS'($urandom_range(0, 160));
            end
            2: begin
               rx = COORD_BITS'($urandom);
               ry = COORD_BITS'($urandom);
               rw = COORD_BITS'($urandom);
               rh = COORD_BITS'($urandom);
            end
            default: begin
               rx = COORD_BITS'(int'(fx) - int'($urandom_range(0, 8)));
               ry = COORD_BITS'(int'(fy) - int'($urandom_range(0, 8)));
               rw = COORD_BITS'($urandom_range(0, 16));
               rh = COORD_BITS'($urandom_range(0, 16));
            end
         endcase
         csr_write(dnrs_pkg::REG_DIRECTION, (p < 4) ? p : int'($urandom_range(0, 3)));
         csr_write(dnrs_pkg::REG_FOCUS_X, 32'(fx));
         csr_write(dnrs_pkg::REG_FOCUS_Y, 32'(fy));
         csr_write(dnrs_pkg::REG_REGION_X, 32'(rx));
         csr_write(dnrs_pkg::REG_REGION_Y, 32'(ry));
         csr_write(dnrs_pkg::REG_REGION_W, 32'(rw));
         csr_write(dnrs_pkg::REG_REGION_H, 32'(rh));
         if ($urandom_range(0, 3) == 0)
            csr_write(REG_SPARE, $urandom);
         if (p == 2)
            long_hold_req = 1'b1;

         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            len = int'($urandom_range(1, 10));
            for (k = 0; k < len; k++) begin
               r.id   = ID_BITS'($urandom);
               r.x    = pick_coord(longint'(cfg_focus_x), longint'(cfg_region_x),
                                   32'(cfg_region_w), px);
               r.y    = pick_coord(longint'(cfg_focus_y), longint'(cfg_region_y),
                                   32'(cfg_region_h), py);
               r.w    = pick_size();
               r.h    = pick_size();
               r.last = (k == len - 1);
               px     = r.x;
               py     = r.y;
               offer_rect(r, 1'b0, none);
               n++;
            end
         end
      end

      settle();
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
